@@ src/assert_macros.svh @@
// Assertion macros for the RTL files; tals_datapath includes them.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every edge outside reset
`define TALS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication checked outside reset
`define TALS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/tals_pkg.sv @@
// Shared types and constants for the two-axis smoothing and lead predictor.
// No dependencies.
package tals_pkg;

  localparam int DATA_W  = 32;
  localparam int ALPHA_W = 17;
  localparam int WLEN_W  = 4;
  localparam int LEAD_W  = 16;
  localparam int CFG_W   = 17;
  localparam int IDX_W   = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_YAW_RST   = 17'd26214;
  localparam logic [ALPHA_W-1:0] ALPHA_PITCH_RST = 17'd32768;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 17'd65536;
  localparam logic [WLEN_W-1:0]  WLEN_RST        = 4'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_ALPHA_YAW   = 2'd0,
    REG_ALPHA_PITCH = 2'd1,
    REG_WINDOW_LEN  = 2'd2,
    REG_LEAD_RATIO  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;       // latch input word, read window slot
    logic lp_mul;     // low-pass multiply
    logic lp_upd;     // low-pass state update
    logic sum_upd;    // window write, sum and count update
    logic div_start;  // start averaging divide
    logic lead_mul;   // lead multiply
    logic out_load;   // load result word
  } tals_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } tals_status_t;

endpackage

@@ src/tals_div.sv @@
// Iterative signed-by-unsigned floor divider, four quotient bits per cycle.
// Uses tals_pkg only by convention; no submodules.
module tals_div import tals_pkg::*; #(
  parameter int NW = 38,
  parameter int DW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int STEPS = (NW + 3) / 4;
  localparam int PW    = STEPS * 4;
  localparam int RW    = DW + 1;
  localparam int SCW   = $clog2(STEPS + 1);

  logic [PW-1:0]  mag, mag_next;
  logic [PW-1:0]  q, q_next;
  logic [RW-1:0]  rem, rem_next;
  logic [DW-1:0]  dreg;
  logic [SCW-1:0] cnt;
  logic           busy, fix, neg;
  logic [NW-1:0]  absval;

  assign absval = num[NW-1] ? NW'(-num) : NW'(num);

  always_comb begin
    logic [RW-1:0] r;
    logic [PW-1:0] m, qq;
    r  = rem;
    m  = mag;
    qq = q;
    for (int i = 0; i < 4; i++) begin
      r  = {r[RW-2:0], m[PW-1]};
      m  = {m[PW-2:0], 1'b0};
      qq = {qq[PW-2:0], 1'b0};
      if (r >= {1'b0, dreg}) begin
        r     = r - {1'b0, dreg};
        qq[0] = 1'b1;
      end
    end
    rem_next = r;
    mag_next = m;
    q_next   = qq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SCW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SCW'(1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= PW'(absval);
      q    <= '0;
      rem  <= '0;
      dreg <= den;
      neg  <= num[NW-1];
    end else if (busy) begin
      mag <= mag_next;
      q   <= q_next;
      rem <= rem_next;
    end else if (fix) begin
      // floor for negative dividends: bump magnitude when inexact
      if (neg) quo <= -$signed(NW'(q) + NW'(rem != '0));
      else     quo <= $signed(NW'(q));
    end
  end

endmodule

@@ src/tals_ctrl.sv @@
// Sequencing state machine: steps one word through filter, window, divide, lead.
// Depends on tals_pkg.
module tals_ctrl import tals_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tals_status_t status,
  output tals_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LP     = 8'b0000_0010,
    S_LPW    = 8'b0000_0100,
    S_SUM    = 8'b0000_1000,
    S_DSTART = 8'b0001_0000,
    S_DWAIT  = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LP;
        end
      end
      S_LP: begin
        cmd.lp_mul = 1'b1;
        state_next = S_LPW;
      end
      S_LPW: begin
        cmd.lp_upd = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_upd = 1'b1;
        state_next  = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.lead_mul = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ src/tals_datapath.sv @@
// Datapath: config registers, low-pass, window store and sums, divider, lead and output.
// Depends on tals_pkg, tals_div and assert_macros.svh.
`include "assert_macros.svh"
module tals_datapath import tals_pkg::*; #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic signed [DATA_W-1:0] yaw_in,
  input  logic signed [DATA_W-1:0] pitch_in,
  output logic signed [DATA_W-1:0] yaw_out,
  output logic signed [DATA_W-1:0] pitch_out,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  tals_cmd_t                cmd,
  output tals_status_t             status
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = (CW > WLEN_W) ? CW : WLEN_W;
  localparam int SW = DATA_W + CW;
  localparam int NW = SW + 2;
  localparam int DW = CW + 1;
  localparam int PLW = ALPHA_W + DATA_W + 2;   // low-pass product
  localparam int PDW = LEAD_W + DATA_W + 2;    // lead product

  logic [ALPHA_W-1:0] alpha [2];
  logic [WLEN_W-1:0]  window_len;
  logic [LEAD_W-1:0]  lead_ratio;

  logic signed [DATA_W-1:0] x [2];
  logic signed [DATA_W-1:0] lp [2];
  logic signed [DATA_W-1:0] rd [2];
  logic signed [DATA_W-1:0] avg [2];
  logic signed [DATA_W-1:0] prev [2];
  logic signed [SW-1:0]     sum [2];
  logic signed [PLW-1:0]    lp_prod [2];
  logic signed [PDW-1:0]    ld_prod [2];
  logic signed [DATA_W-1:0] mem [2][MAX_WINDOW];
  logic signed [NW-1:0]     div_num [2];
  logic signed [NW-1:0]     div_quo [2];
  logic [1:0]               div_done;
  logic signed [DATA_W-1:0] res [2];

  logic [AW-1:0] slot;
  logic [CW-1:0] fill;
  logic [CW-1:0] len_eff;
  logic          lp_started, pr_started;
  logic [LW-1:0] wl;
  logic [CW:0]   slot_inc;
  logic          filling;

  assign wl = LW'(window_len);
  always_comb begin
    if (wl == '0)                   len_eff = CW'(1);
    else if (wl > LW'(MAX_WINDOW))  len_eff = CW'(MAX_WINDOW);
    else                            len_eff = CW'(wl);
  end

  assign slot_inc = (CW+1)'(slot) + 1'b1;
  assign filling  = (fill < len_eff);

  assign status.out_free = !out_valid || out_ready;
  assign status.div_done = div_done[0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha[0]   <= ALPHA_YAW_RST;
      alpha[1]   <= ALPHA_PITCH_RST;
      window_len <= WLEN_RST;
      lead_ratio <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_ALPHA_YAW:   alpha[0]   <= cfg_data;
        REG_ALPHA_PITCH: alpha[1]   <= cfg_data;
        REG_WINDOW_LEN:  window_len <= cfg_data[WLEN_W-1:0];
        REG_LEAD_RATIO:  lead_ratio <= cfg_data[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // control state and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      fill       <= '0;
      lp_started <= 1'b0;
      pr_started <= 1'b0;
      out_valid  <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        sum[a]  <= '0;
        lp[a]   <= '0;
        prev[a] <= '0;
      end
    end else begin
      if (cfg_wr_en && reg_idx_t'(cfg_index) == REG_WINDOW_LEN) begin
        slot <= '0;
        fill <= '0;
        for (int a = 0; a < 2; a++) sum[a] <= '0;
      end
      if (cmd.lp_upd) begin
        lp_started <= 1'b1;
        for (int a = 0; a < 2; a++) begin
          if (lp_started)
            lp[a] <= lp[a] + DATA_W'((lp_prod[a] + PLW'(32768)) >>> 16);
          else
            lp[a] <= x[a];
        end
      end
      if (cmd.sum_upd) begin
        // slots not yet filled since the last clear count as zero
        for (int a = 0; a < 2; a++)
          sum[a] <= sum[a] - (filling ? SW'(0) : SW'(rd[a])) + SW'(lp[a]);
        if (filling) fill <= fill + 1'b1;
        slot <= (slot_inc >= (CW+1)'(len_eff)) ? '0 : AW'(slot_inc);
      end
      if (cmd.out_load) begin
        pr_started <= 1'b1;
        for (int a = 0; a < 2; a++) prev[a] <= avg[a];
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      if (cmd.sum_upd) mem[a][slot] <= lp[a];
      if (cmd.load)    rd[a] <= mem[a][slot];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    logic [ALPHA_W-1:0] w;
    if (cmd.load) begin
      x[0] <= yaw_in;
      x[1] <= pitch_in;
    end
    for (int a = 0; a < 2; a++) begin
      w = alpha[a][ALPHA_W-1] ? ALPHA_ONE : alpha[a];
      if (cmd.lp_mul)
        lp_prod[a] <= PLW'($signed({1'b0, w}) *
                      ($signed({x[a][DATA_W-1], x[a]}) - $signed({lp[a][DATA_W-1], lp[a]})));
      if (div_done[a]) avg[a] <= DATA_W'(div_quo[a]);
      if (cmd.lead_mul)
        ld_prod[a] <= PDW'($signed({1'b0, lead_ratio}) *
                      ($signed({avg[a][DATA_W-1], avg[a]}) -
                       $signed({prev[a][DATA_W-1], prev[a]})));
    end
    if (cmd.out_load) begin
      yaw_out   <= res[0];
      pitch_out <= res[1];
    end
  end

  // lead add and saturation
  always_comb begin
    logic signed [PDW-1:0] s;
    for (int a = 0; a < 2; a++) begin
      s = PDW'(avg[a]) + ((ld_prod[a] + PDW'(128)) >>> 8);
      if (!pr_started)
        res[a] = avg[a];
      else if (s > PDW'(32'sh7fff_ffff))
        res[a] = 32'sh7fff_ffff;
      else if (s < PDW'(-64'sh8000_0000))
        res[a] = 32'sh8000_0000;
      else
        res[a] = DATA_W'(s);
    end
  end

  // avg = floor((2*sum + n) / (2*n))
  for (genvar a = 0; a < 2; a++) begin : g_div
    assign div_num[a] = $signed({sum[a], 1'b0}) + $signed({{(NW-CW){1'b0}}, fill});
    tals_div #(.NW(NW), .DW(DW)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (cmd.div_start),
      .num   (div_num[a]),
      .den   ({fill, 1'b0}),
      .done  (div_done[a]),
      .quo   (div_quo[a])
    );
  end

  `TALS_ASSERT(a_fill_le_len, (fill <= len_eff), "fill count above window length")
  `TALS_ASSERT(a_slot_lt_len, ((CW+1)'(slot) < (CW+1)'(len_eff)), "write slot outside window")
  `TALS_ASSERT_IMP(a_no_overwrite, cmd.out_load, (!out_valid || out_ready), "result word lost")

endmodule

@@ src/two_axis_smoothing_and_lead_predictor.sv @@
// Top level of the two-axis smoothing and lead predictor.
// Depends on tals_pkg, tals_ctrl, tals_datapath (and tals_div below it).
//
// Input channel: in_valid/in_ready with yaw_in and pitch_in (signed Q16.16).
// Output channel: out_valid/out_ready with yaw_out and pitch_out, one word
// per input word, in order. Each axis is low-pass filtered, averaged over
// window_len samples, held to 1..MAX_WINDOW (count so far until full), and
// lead-extrapolated. Config: cfg_wr_en writes cfg_data to register cfg_index
// (0 alpha_yaw, 1 alpha_pitch, 2 window_len, 3 lead_ratio); writing window_len
// clears the window store. Write only while idle.
// Timing: one word at a time. A word steps from acceptance through low-pass multiply,
// low-pass update, window update, divide start and divide wait (mostly the radix-16
// iterative divider for the average), lead multiply and output load, then back to
// idle before the next word is taken.
// The result sits in an output register; a stalled receiver holds it while the
// next word is taken and worked, which then waits to load until the slot frees.
// Reset: synchronous, active high; clears filters, window, predictor and sets
// register defaults. No clearing pass is needed.
module two_axis_smoothing_and_lead_predictor import tals_pkg::*; #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] yaw_in,
  input  logic signed [DATA_W-1:0] pitch_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] yaw_out,
  output logic signed [DATA_W-1:0] pitch_out
);

  tals_cmd_t    cmd;
  tals_status_t status;

  tals_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tals_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .yaw_in    (yaw_in),
    .pitch_in  (pitch_in),
    .yaw_out   (yaw_out),
    .pitch_out (pitch_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ verif/two_axis_smoothing_and_lead_predictor_tb.sv @@
// Testbench for two_axis_smoothing_and_lead_predictor: directed and random words,
// checked against a predictor of the low-pass, moving-average and lead stages.
// Depends on tals_pkg and the RTL under src.
module two_axis_smoothing_and_lead_predictor_tb;
  import tals_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] yaw;
    logic signed [DATA_W-1:0] pitch;
  } aim_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] yaw_in = '0;
  logic signed [DATA_W-1:0] pitch_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] yaw_out;
  logic signed [DATA_W-1:0] pitch_out;

  two_axis_smoothing_and_lead_predictor u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .yaw_in(yaw_in), .pitch_in(pitch_in), .out_valid(out_valid),
    .out_ready(out_ready), .yaw_out(yaw_out), .pitch_out(pitch_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int unsigned alpha_y, alpha_p, wlen, lead;
  longint lp_y, lp_p, sum_y, sum_p, prev_y, prev_p;
  longint win_y[8], win_p[8];
  bit lp_started, lead_started;
  int unsigned slot_wr, fill;

  aim_word_t aim_q[$];
  int  n_fail = 0;
  int  n_sent = 0;
  int  n_seen = 0;
  bit  quiet = 1'b0;      // no idling on either side
  bit  rx_hold = 1'b0;    // long receiver stall request

  function automatic longint fdiv(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 8; i++) begin
      win_y[i] = 0;
      win_p[i] = 0;
    end
    sum_y = 0;
    sum_p = 0;
    slot_wr = 0;
    fill = 0;
  endfunction

  function automatic longint lowpass(longint st, longint x, int unsigned a);
    longint w;
    w = (a > 65536) ? 65536 : a;
    return fdiv(w * x + (65536 - w) * st + 32768, 65536);
  endfunction

  function automatic longint lead_out(longint x, longint prv);
    if (!lead_started) return x;
    return sat32(x + fdiv((x - prv) * longint'(lead) + 128, 256));
  endfunction

  function automatic aim_word_t smooth_and_lead(logic signed [31:0] y, logic signed [31:0] p);
    int unsigned len, s;
    longint ay, ap, cnt;
    aim_word_t r;
    len = (wlen < 1) ? 1 : (wlen > 8) ? 8 : wlen;
    s = (slot_wr >= len) ? 0 : slot_wr;
    lp_y = lp_started ? lowpass(lp_y, longint'(y), alpha_y) : longint'(y);
    lp_p = lp_started ? lowpass(lp_p, longint'(p), alpha_p) : longint'(p);
    lp_started = 1'b1;
    if (fill < len) fill++;
    cnt = longint'(fill);
    sum_y = sum_y - win_y[s] + lp_y;
    win_y[s] = lp_y;
    sum_p = sum_p - win_p[s] + lp_p;
    win_p[s] = lp_p;
    ay = fdiv(2 * sum_y + cnt, 2 * cnt);
    ap = fdiv(2 * sum_p + cnt, 2 * cnt);
    s++;
    slot_wr = (s >= len) ? 0 : s;
    r.yaw = 32'(lead_out(ay, prev_y));
    r.pitch = 32'(lead_out(ap, prev_p));
    prev_y = ay;
    prev_p = ap;
    lead_started = 1'b1;
    return r;
  endfunction

  // all tasks are entered just after a rising edge
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ALPHA_YAW:   alpha_y = 32'(val);
      REG_ALPHA_PITCH: alpha_p = 32'(val);
      REG_WINDOW_LEN: begin
        wlen = 32'(val[WLEN_W-1:0]);
        clear_window();
      end
      REG_LEAD_RATIO:  lead = 32'(val[LEAD_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (aim_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_word(logic signed [31:0] y, logic signed [31:0] p);
    in_valid <= 1'b1;
    yaw_in <= y;
    pitch_in <= p;
    do @(posedge clk); while (!in_ready);
    aim_q.push_back(smooth_and_lead(y, p));
    n_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // receiver side ready pattern
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        rx_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_seen++;
      if (aim_q.size() == 0) begin
        $error("result word with nothing expected: yaw %0d pitch %0d", yaw_out, pitch_out);
        n_fail++;
      end else begin
        aim_word_t e;
        e = aim_q.pop_front();
        if (yaw_out !== e.yaw) begin
          $error("yaw_out expected %0d actual %0d", e.yaw, yaw_out);
          n_fail++;
        end
        if (pitch_out !== e.pitch) begin
          $error("pitch_out expected %0d actual %0d", e.pitch, pitch_out);
          n_fail++;
        end
      end
    end
  end

  task automatic test_defaults();
    send_word(32'sd65536, -32'sd65536);
    send_word(32'sd0, 32'sd0);
    send_word(32'sd1000, 32'sd3);
    send_word(-32'sd77777, 32'sd123456);
  endtask

  task automatic test_extremes();
    drain();
    write_reg(REG_ALPHA_YAW, 17'd65536);
    write_reg(REG_ALPHA_PITCH, 17'd0);
    write_reg(REG_LEAD_RATIO, 17'h0FFFF);
    write_reg(REG_WINDOW_LEN, 17'd1);
    send_word(32'h7FFFFFFF, 32'h80000000);
    send_word(32'h80000000, 32'h7FFFFFFF);
    send_word(32'h7FFFFFFF, 32'h80000000);
    send_word(32'h00000000, 32'hFFFFFFFF);
    drain();
    // alpha above one, window length zero
    write_reg(REG_ALPHA_YAW, 17'h1FFFF);
    write_reg(REG_ALPHA_PITCH, 17'd65537);
    write_reg(REG_WINDOW_LEN, 17'd0);
    send_word(32'h12345678, 32'hEDCBA987);
    send_word(-32'sd1, 32'sd1);
    drain();
    // window length above the store depth
    write_reg(REG_WINDOW_LEN, 17'd15);
    write_reg(REG_ALPHA_YAW, 17'd1);
    write_reg(REG_LEAD_RATIO, 17'd256);
    for (int i = 0; i < 10; i++) send_word(32'sd100000 * i, -32'sd50000 * i);
    drain();
    write_reg(REG_WINDOW_LEN, 17'd8);
    write_reg(REG_LEAD_RATIO, 17'd0);
    send_word(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(32'h80000000, 32'h80000000);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    longint py, pp;
    int dy, dp;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      if (ph == phases - 1) quiet = 1'b1;
      write_reg(REG_ALPHA_YAW, ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 131071))
                                                          : CFG_W'($urandom_range(0, 65536)));
      write_reg(REG_ALPHA_PITCH, ($urandom_range(0, 3) == 0) ? CFG_W'(65536)
                                                            : CFG_W'($urandom_range(0, 65536)));
      write_reg(REG_LEAD_RATIO, ($urandom_range(0, 4) == 0) ? CFG_W'(16'hFFFF)
                                                           : CFG_W'($urandom_range(0, 2048)));
      write_reg(REG_WINDOW_LEN, CFG_W'($urandom_range(0, 15)));
      py = longint'($signed($urandom) >>> 4);
      pp = longint'($signed($urandom) >>> 4);
      dy = int'($urandom_range(0, 20000)) - 10000;
      dp = int'($urandom_range(0, 20000)) - 10000;
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          // smooth aim track with jitter
          dy += int'($urandom_range(0, 400)) - 200;
          dp += int'($urandom_range(0, 400)) - 200;
          py = sat32(py + longint'(dy) + longint'($urandom_range(0, 2000)) - 1000);
          pp = sat32(pp + longint'(dp) + longint'($urandom_range(0, 2000)) - 1000);
          send_word(32'(py), 32'(pp));
        end else begin
          send_word($urandom, $urandom);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    write_reg(REG_LEAD_RATIO, 17'd384);
    rx_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_word($urandom, $urandom);
  endtask

  task automatic test_sender_pause();
    drain();
    for (int i = 0; i < 6; i++) send_word($urandom_range(0, 65535), -$urandom_range(0, 65535));
  endtask

  initial begin
    alpha_y = 32'(ALPHA_YAW_RST);
    alpha_p = 32'(ALPHA_PITCH_RST);
    wlen = 32'(WLEN_RST);
    lead = 0;
    lp_y = 0; lp_p = 0; prev_y = 0; prev_p = 0;
    lp_started = 1'b0;
    lead_started = 1'b0;
    clear_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_backpressure();
    test_sender_pause();
    test_random_phases(9, 120);
    drain();
    $display("covered %0d words sent, %0d results checked, over varied filter settings",
             n_sent, n_seen);
    if (n_fail == 0) $display("two_axis_smoothing_and_lead_predictor regression: pass");
    else $display("two_axis_smoothing_and_lead_predictor regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("two_axis_smoothing_and_lead_predictor regression: fail");
    $finish;
  end

endmodule
